// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CHK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/sha_pkg.sv =====
package sha_pkg;

  localparam int WORD_W  = 32;
  localparam int NB_W    = 3;
  localparam int IDX_W   = 3;
  localparam int LEN_W   = 64;
  localparam int FILL_W  = 6;
  localparam int ROUND_W = 6;

  localparam logic [NB_W-1:0]    BYTES_PER_WORD = 3'd4;
  localparam logic [FILL_W-1:0]  LEN_POS        = 6'd56;
  localparam logic [FILL_W-1:0]  LAST_POS       = 6'd63;
  localparam logic [ROUND_W-1:0] LAST_ROUND     = 6'd63;
  localparam logic [IDX_W-1:0]   LAST_IDX       = 3'd7;
  localparam logic [7:0]         PAD_MARK       = 8'h80;

  localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PUT  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_SEND = 5'b10000
  } state_t;

  typedef enum logic [5:0] {
    PH_NONE = 6'b000001,
    PH_DATA = 6'b000010,
    PH_MARK = 6'b000100,
    PH_ZERO = 6'b001000,
    PH_LEN  = 6'b010000,
    PH_OUT  = 6'b100000
  } phase_t;

  function automatic logic [WORD_W-1:0] big_s0(input logic [WORD_W-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WORD_W-1:0] big_s1(input logic [WORD_W-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WORD_W-1:0] small_s0(input logic [WORD_W-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [WORD_W-1:0] small_s1(input logic [WORD_W-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

endpackage

// ===== hw/rtl/sha_if.sv =====
interface sha_msg_if;
  logic                       valid;
  logic                       ready;
  logic [sha_pkg::WORD_W-1:0] msg_word;
  logic [sha_pkg::NB_W-1:0]   valid_bytes;
  logic                       final_word;

  modport source(output valid, msg_word, valid_bytes, final_word, input ready);
  modport sink(input valid, msg_word, valid_bytes, final_word, output ready);
endinterface

interface sha_dig_if;
  logic                       valid;
  logic                       ready;
  logic [sha_pkg::WORD_W-1:0] digest_word;
  logic [sha_pkg::IDX_W-1:0]  word_index;
  logic                       last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hw/rtl/sha256_hash.sv =====
// sha-256 engine, one round per cycle on a single round unit
// msg channel: big-endian message words with 0 to 4 leading valid bytes;
//   final_word closes the message. only the final word may be short.
// digest channel: eight beats, H0 first, word_index 0..7, last_word on 7.
// msg.ready is high only while the engine is idle; after each accepted word
//   its valid bytes enter the block buffer one per cycle, pausing while a
//   filled block is compressed, before the engine is idle again.
// each filled 64-byte block takes 64 rounds on the round unit, after
//   which the working variables are folded into the chain hash.
// a final word adds up to 72 padding bytes and one or two blocks,
//   then the digest beats start; the first beat follows the chain update.
// the digest beats hold while digest.ready is low; no new word is taken
//   until the eighth beat is accepted, after which the chain hash is
//   reloaded and the length count cleared for the next message.
// reset (rst, synchronous) loads the initial hash and empties the block;
//   msg.ready rises in the same cycle that reset falls.
`include "assert_macros.svh"

module sha256_hash (
  input  logic       clk,
  input  logic       rst,
  sha_msg_if.sink    msg,
  sha_dig_if.source  digest
);
  import sha_pkg::*;

  state_t                state;
  phase_t                phase;
  logic [FILL_W-1:0]     fill;
  logic [LEN_W-1:0]      bit_length;
  logic [ROUND_W-1:0]    round_count;
  logic [NB_W-1:0]       nb_left;
  logic                  fin;
  logic [2:0]            len_cnt;
  logic [IDX_W-1:0]      oidx;
  logic [WORD_W-1:0]     chain_hash [8];
  logic [WORD_W-1:0]     word_sr;
  logic [WORD_W-1:0]     block_buffer [16];
  logic [WORD_W-1:0]     work_vars [8];

  logic                  in_fire;
  logic                  out_fire;
  logic [NB_W-1:0]       nb_in;
  phase_t                phase_in;
  phase_t                phase_put;
  logic [7:0]            put_val;
  logic [FILL_W-1:0]     fill_inc;
  logic [WORD_W-1:0]     t1;
  logic [WORD_W-1:0]     t2;
  logic [WORD_W-1:0]     w_new;

  function automatic state_t resume(input phase_t ph);
    unique case (ph)
      PH_NONE: return ST_IDLE;
      PH_OUT:  return ST_SEND;
      default: return ST_PUT;
    endcase
  endfunction

  assign in_fire  = msg.valid && msg.ready;
  assign out_fire = digest.valid && digest.ready;

  assign msg.ready          = (state == ST_IDLE) && !rst;
  assign digest.valid       = (state == ST_SEND) && !rst;
  assign digest.digest_word = chain_hash[oidx];
  assign digest.word_index  = oidx;
  assign digest.last_word   = (oidx == LAST_IDX);

  assign nb_in    = (msg.valid_bytes > BYTES_PER_WORD) ? BYTES_PER_WORD : msg.valid_bytes;
  assign fill_inc = fill + FILL_W'(1);

  always_comb begin
    if (nb_in != '0) begin
      phase_in = PH_DATA;
    end else if (msg.final_word) begin
      phase_in = PH_MARK;
    end else begin
      phase_in = PH_NONE;
    end
  end

  // byte source and the phase that follows this byte
  always_comb begin
    put_val   = '0;
    phase_put = phase;
    unique case (phase)
      PH_DATA: begin
        put_val = word_sr[31:24];
        if (nb_left == 3'd1) begin
          phase_put = fin ? PH_MARK : PH_NONE;
        end
      end
      PH_MARK, PH_ZERO: begin
        put_val   = (phase == PH_MARK) ? PAD_MARK : 8'h00;
        phase_put = (fill_inc == LEN_POS) ? PH_LEN : PH_ZERO;
      end
      PH_LEN: begin
        put_val   = bit_length[63:56];
        phase_put = (len_cnt == 3'd7) ? PH_OUT : PH_LEN;
      end
      default: begin
        put_val   = '0;
        phase_put = phase;
      end
    endcase
  end

  // round unit and message schedule
  always_comb begin
    t1 = work_vars[7] + big_s1(work_vars[4])
       + ((work_vars[4] & work_vars[5]) ^ (~work_vars[4] & work_vars[6]))
       + ROUND_K[round_count] + block_buffer[0];
    t2 = big_s0(work_vars[0])
       + ((work_vars[0] & work_vars[1]) ^ (work_vars[0] & work_vars[2])
          ^ (work_vars[1] & work_vars[2]));
    w_new = block_buffer[0] + small_s0(block_buffer[1]) + block_buffer[9]
          + small_s1(block_buffer[14]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_NONE;
      fill        <= '0;
      bit_length  <= '0;
      round_count <= '0;
      nb_left     <= '0;
      fin         <= 1'b0;
      len_cnt     <= '0;
      oidx        <= '0;
      for (int i = 0; i < 8; i++) chain_hash[i] <= INIT_HASH[i];
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            nb_left <= nb_in;
            fin     <= msg.final_word;
            phase   <= phase_in;
            state   <= resume(phase_in);
          end
        end
        ST_PUT: begin
          fill  <= fill_inc;
          phase <= phase_put;
          if (phase == PH_DATA) begin
            bit_length <= bit_length + 64'd8;
            nb_left    <= nb_left - NB_W'(1);
          end
          if (phase == PH_LEN) begin
            bit_length <= bit_length << 8;
            len_cnt    <= len_cnt + 3'd1;
          end
          if (fill == LAST_POS) begin
            round_count <= '0;
            state       <= ST_COMP;
          end else begin
            state <= resume(phase_put);
          end
        end
        ST_COMP: begin
          round_count <= round_count + ROUND_W'(1);
          if (round_count == LAST_ROUND) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          for (int i = 0; i < 8; i++) chain_hash[i] <= chain_hash[i] + work_vars[i];
          state <= resume(phase);
        end
        ST_SEND: begin
          if (out_fire) begin
            oidx <= oidx + IDX_W'(1);
            if (oidx == LAST_IDX) begin
              for (int i = 0; i < 8; i++) chain_hash[i] <= INIT_HASH[i];
              fill       <= '0;
              bit_length <= '0;
              phase      <= PH_NONE;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_sr <= msg.msg_word;
    end
    if (state == ST_PUT) begin
      block_buffer[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= put_val;
      if (phase == PH_DATA) begin
        word_sr <= word_sr << 8;
      end
      if (fill == LAST_POS) begin
        for (int i = 0; i < 8; i++) work_vars[i] <= chain_hash[i];
      end
    end
    if (state == ST_COMP) begin
      for (int i = 0; i < 15; i++) block_buffer[i] <= block_buffer[i + 1];
      block_buffer[15] <= w_new;
      work_vars[7] <= work_vars[6];
      work_vars[6] <= work_vars[5];
      work_vars[5] <= work_vars[4];
      work_vars[4] <= work_vars[3] + t1;
      work_vars[3] <= work_vars[2];
      work_vars[2] <= work_vars[1];
      work_vars[1] <= work_vars[0];
      work_vars[0] <= t1 + t2;
    end
  end

  // a block is only compressed once its last byte has wrapped the fill count
  `CHK_ASSERT(a_comp_fill, state == ST_COMP |-> fill == '0)
  `CHK_ASSERT(a_last_round, state == ST_COMP && round_count == LAST_ROUND |=> state == ST_UPD)
  `CHK_ASSERT(a_send_phase, digest.valid |-> phase == PH_OUT && fill == '0 && len_cnt == '0)
  `CHK_ASSERT(a_rearm,
    out_fire && digest.last_word |=> state == ST_IDLE && fill == '0 && bit_length == '0)
  `CHK_ASSERT_ALWAYS(a_reset_idle, rst |=> state == ST_IDLE && oidx == '0)

endmodule
